### rtl/core/stq_pkg.sv
// Package with sizes, entry type and status codes of the sleep timer queue.
package stq_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W       = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int CHILD_W     = IDX_W + 2;
	localparam int WAKE_W      = 32;
	localparam int ID_W        = 4;
	localparam int OCC_W       = 5;
	localparam int STATUS_W    = 2;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_WOKEN = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		CMD_SLEEP = 1'b0,
		CMD_CHECK = 1'b1
	} command_t;

	typedef struct packed {
		logic [WAKE_W-1:0] wake;
		logic [ID_W-1:0]   id;
	} entry_t;

endpackage

### rtl/core/stq_req_if.sv
// Request channel of the sleep timer queue: command, task, delay and current tick.
interface stq_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [3:0]  task_id;
	logic [31:0] delay;
	logic [31:0] now;

	modport source (output valid, output command, output task_id, output delay,
		output now, input ready);
	modport sink (input valid, input command, input task_id, input delay,
		input now, output ready);
endinterface

### rtl/core/stq_rsp_if.sv
// Response channel of the sleep timer queue: status, woken task and occupancy.
interface stq_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [3:0] woken_task;
	logic [4:0] occupancy;

	modport source (output valid, output status, output woken_task, output occupancy,
		input ready);
	modport sink (input valid, input status, input woken_task, input occupancy,
		output ready);
endinterface

### rtl/core/sleep_timer_queue_top.sv
// Sleep timer queue: a min-heap of wake times kept in a small memory and sifted by one comparator.
// Full sleeps and empty-queue checks respond at once; a check with nothing due reads and compares.
// A stored sleep reads and compares its parent per level climbed and is written where it stops.
// A wake reads both children, selects one and compares per level sunk, down to where it stops.
// One transaction per heap walk, plus response stalls.
// Reset empties the queue at once and clears the response; heap contents are left as they are.
module sleep_timer_queue_top (
	input logic clk,
	input logic arst_n,
	stq_req_if.sink req,
	stq_rsp_if.source rsp
);
	import stq_pkg::*;

	localparam int EXT_W = CNT_W + OCC_W;

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_INS_RD  = 9'b000000010,
		S_INS_CMP = 9'b000000100,
		S_CHK_RD  = 9'b000001000,
		S_CHK_CMP = 9'b000010000,
		S_REM_RD  = 9'b000100000,
		S_REM_SEL = 9'b001000000,
		S_REM_CMP = 9'b010000000,
		S_DONE    = 9'b100000000
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] cidx_q;
	entry_t moving_q;
	entry_t child_q;
	logic [WAKE_W-1:0] now_q;
	status_t status_q;
	logic [ID_W-1:0] woken_q;

	logic rsp_valid_q;
	status_t rsp_status_q;
	logic [ID_W-1:0] rsp_woken_q;
	logic [OCC_W-1:0] rsp_occ_q;

	entry_t heap_mem [MAX_ENTRIES];
	entry_t rdata_a_q;
	entry_t rdata_b_q;
	logic [IDX_W-1:0] rd_addr_a;
	logic [IDX_W-1:0] rd_addr_b;
	logic mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t mem_wdata;

	entry_t cmp_a;
	entry_t cmp_b;
	logic [WAKE_W-1:0] cmp_diff;
	logic cmp_prec;
	logic cmp_due;

	logic [IDX_W-1:0] parent_idx;
	logic [CHILD_W-1:0] left_idx;
	logic [CHILD_W-1:0] right_idx;
	logic [CHILD_W-1:0] count_ext;
	logic left_in;
	logic right_in;
	logic is_full;
	logic [EXT_W-1:0] occ_ext;
	logic rsp_load;

	assign parent_idx = (idx_q - IDX_W'(1)) >> 1;
	assign left_idx   = (CHILD_W'(idx_q) << 1) + CHILD_W'(1);
	assign right_idx  = left_idx + CHILD_W'(1);
	assign count_ext  = CHILD_W'(count_q);
	assign left_in    = left_idx < count_ext;
	assign right_in   = right_idx < count_ext;
	assign is_full    = count_q == CNT_W'(MAX_ENTRIES);
	assign occ_ext    = EXT_W'(count_q);
	assign rsp_load   = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		cmp_a = moving_q;
		cmp_b = rdata_a_q;
		unique case (state_q)
			S_CHK_CMP: begin
				cmp_a = '{wake: now_q, id: '0};
				cmp_b = rdata_a_q;
			end
			S_REM_SEL: begin
				cmp_a = rdata_b_q;
				cmp_b = rdata_a_q;
			end
			S_REM_CMP: begin
				cmp_a = child_q;
				cmp_b = moving_q;
			end
			default: begin
				cmp_a = moving_q;
				cmp_b = rdata_a_q;
			end
		endcase
	end

	assign cmp_diff = cmp_a.wake - cmp_b.wake;
	assign cmp_prec = (cmp_diff == '0) ? (cmp_a.id < cmp_b.id) : cmp_diff[WAKE_W-1];
	assign cmp_due  = (cmp_diff != '0) && !cmp_diff[WAKE_W-1];

	always_comb begin
		rd_addr_a = '0;
		rd_addr_b = '0;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = moving_q;
		unique case (state_q)
			S_INS_RD: begin
				rd_addr_a = parent_idx;
				mem_we    = idx_q == '0;
			end
			S_INS_CMP: begin
				mem_we    = 1'b1;
				mem_wdata = cmp_prec ? rdata_a_q : moving_q;
			end
			S_CHK_RD: begin
				rd_addr_b = IDX_W'(count_q - CNT_W'(1));
			end
			S_REM_RD: begin
				rd_addr_a = left_idx[IDX_W-1:0];
				rd_addr_b = right_idx[IDX_W-1:0];
				mem_we    = !left_in;
			end
			S_REM_CMP: begin
				mem_we    = 1'b1;
				mem_wdata = cmp_prec ? child_q : moving_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			heap_mem[mem_waddr] <= mem_wdata;
		end
		rdata_a_q <= heap_mem[rd_addr_a];
		rdata_b_q <= heap_mem[rd_addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						if (req.command == CMD_SLEEP) begin
							state_q <= is_full ? S_DONE : S_INS_RD;
							if (!is_full) begin
								count_q <= count_q + CNT_W'(1);
							end
						end else begin
							state_q <= (count_q == '0) ? S_DONE : S_CHK_RD;
						end
					end
				end
				S_INS_RD: begin
					state_q <= (idx_q == '0) ? S_DONE : S_INS_CMP;
				end
				S_INS_CMP: begin
					state_q <= cmp_prec ? S_INS_RD : S_DONE;
				end
				S_CHK_RD: begin
					state_q <= S_CHK_CMP;
				end
				S_CHK_CMP: begin
					state_q <= cmp_due ? S_REM_RD : S_DONE;
					if (cmp_due) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
				S_REM_RD: begin
					state_q <= left_in ? S_REM_SEL : S_DONE;
				end
				S_REM_SEL: begin
					state_q <= S_REM_CMP;
				end
				S_REM_CMP: begin
					state_q <= cmp_prec ? S_REM_RD : S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				moving_q <= '{wake: req.now + req.delay, id: req.task_id};
				now_q    <= req.now;
				idx_q    <= IDX_W'(count_q);
				woken_q  <= '0;
				status_q <= (req.command == CMD_SLEEP && is_full) ? STAT_FULL : STAT_OK;
			end
			S_INS_CMP: begin
				if (cmp_prec) begin
					idx_q <= parent_idx;
				end
			end
			S_CHK_CMP: begin
				if (cmp_due) begin
					status_q <= STAT_WOKEN;
					woken_q  <= rdata_a_q.id;
					moving_q <= rdata_b_q;
					idx_q    <= '0;
				end
			end
			S_REM_SEL: begin
				if (right_in && cmp_prec) begin
					child_q <= rdata_b_q;
					cidx_q  <= right_idx[IDX_W-1:0];
				end else begin
					child_q <= rdata_a_q;
					cidx_q  <= left_idx[IDX_W-1:0];
				end
			end
			S_REM_CMP: begin
				if (cmp_prec) begin
					idx_q <= cidx_q;
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_status_q <= status_q;
			rsp_woken_q  <= woken_q;
			rsp_occ_q    <= occ_ext[OCC_W-1:0];
		end
	end

	assign req.ready      = state_q == S_IDLE;
	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.woken_task = rsp_woken_q;
	assign rsp.occupancy  = rsp_occ_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("Sleep queue count exceeds its capacity.");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load && status_q == STAT_FULL |-> is_full)
		else $error("Full status reported while the queue has room.");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("Request taken while a transaction is still in progress.");

	a_woken_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load && status_q != STAT_WOKEN |-> woken_q == '0)
		else $error("Woken task id set without a wake status.");

endmodule
